/* sv/sjfaw_pkg.sv */
package sjfaw_pkg;

  // Field widths of the job and result beats.
  localparam int unsigned ARRIVAL_W   = 16;
  localparam int unsigned BURST_W     = 16;
  localparam int unsigned WAIT_W      = 25;
  localparam int unsigned AVG_W       = 33;
  localparam int unsigned COUNT_OUT_W = 5;

  // Fraction bits of the average and the number of divider steps.
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned DIV_STEPS = WAIT_W + FRAC_W;

  // Default job store depth.
  localparam int unsigned MAX_JOBS_DEF = 16;

endpackage

/* sv/sjf_average_wait_core.sv */
// Non-preemptive shortest-job-first evaluator.
// Input channel (in_valid / in_stall): each beat loads one job (arrival time,
// burst length). The beat with in_last_job set loads its job and starts the
// schedule of the batch. Jobs beyond MAX_JOBS are dropped and set the
// overflow flag of that batch.
// Result channel (out_valid / out_stall): one beat per batch with the total
// wait, the average wait (UQ25.8, truncated), the job count and overflow.
// Sequence: after the last job beat, each selection round scans the loaded
// jobs through the store's registered read port and then decides (n = jobs
// loaded); a round that finds no arrived job only moves the clock, so a
// nonempty batch has at most 2n rounds. The average then comes from a
// restoring divider at one quotient bit per cycle, and the result is posted
// once the output register is free.
// in_stall is high for the whole evaluation. Job beats are taken again while
// the result beat still waits; a new evaluation posts its result only after
// the previous one is taken. A stalled result holds its value.
// Reset (synchronous, rst_n low) empties the job store and drops any pending
// result.
module sjf_average_wait_core #(
  parameter int unsigned MAX_JOBS = sjfaw_pkg::MAX_JOBS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sjfaw_pkg::ARRIVAL_W-1:0]     in_job_arrival,
  input  logic [sjfaw_pkg::BURST_W-1:0]       in_job_burst,
  input  logic                                in_last_job,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sjfaw_pkg::WAIT_W-1:0]        out_total_wait,
  output logic [sjfaw_pkg::AVG_W-1:0]         out_average_wait_q8,
  output logic [sjfaw_pkg::COUNT_OUT_W-1:0]   out_job_count,
  output logic                                out_overflow
);

  localparam int unsigned AW  = sjfaw_pkg::ARRIVAL_W;
  localparam int unsigned BW  = sjfaw_pkg::BURST_W;
  localparam int unsigned WW  = sjfaw_pkg::WAIT_W;
  localparam int unsigned QW  = sjfaw_pkg::AVG_W;
  localparam int unsigned CW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CKW = AW + CW;
  localparam int unsigned SW  = $clog2(sjfaw_pkg::DIV_STEPS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // Job store.
  logic [AW-1:0] arr_mem [MAX_JOBS];
  logic [BW-1:0] bur_mem [MAX_JOBS];

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       loaded_r, loaded_nxt;
  logic                dropped_r, dropped_nxt;
  logic [MAX_JOBS-1:0] fin_r, fin_nxt;
  logic [CKW-1:0]      clock_r, clock_nxt;
  logic [WW-1:0]       sum_r, sum_nxt;
  logic [CW-1:0]       done_r, done_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]       rd_arr_r;
  logic [BW-1:0]       rd_bur_r;
  logic                rd_fin_r;
  logic [IW-1:0]       rd_idx_r;
  logic                found_r, found_nxt;
  logic [AW-1:0]       best_arr_r, best_arr_nxt;
  logic [BW-1:0]       best_bur_r, best_bur_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic                any_r, any_nxt;
  logic [AW-1:0]       earliest_r, earliest_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [QW-1:0]       quo_r, quo_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WW-1:0]       out_wait_r, out_wait_nxt;
  logic [QW-1:0]       out_avg_r, out_avg_nxt;
  logic [sjfaw_pkg::COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic          store_full;
  logic          wr_en;
  logic [IW-1:0] rd_addr;
  logic          cand;
  logic          pending;
  logic [WW-1:0] sum_add;
  logic [CW:0]   trial;

  assign store_full = (loaded_r == CW'(MAX_JOBS));
  assign wr_en      = (state_r == ST_IDLE) && in_valid && !store_full;
  assign rd_addr    = iss_r[IW-1:0];

  // Store write on a job beat; registered read for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      arr_mem[loaded_r[IW-1:0]] <= in_job_arrival;
      bur_mem[loaded_r[IW-1:0]] <= in_job_burst;
    end
    rd_arr_r <= arr_mem[rd_addr];
    rd_bur_r <= bur_mem[rd_addr];
    rd_fin_r <= fin_r[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // Scan compare: arrived and unfinished, and unfinished at all.
  assign cand    = !rd_fin_r && (CKW'(rd_arr_r) <= clock_r);
  assign pending = !rd_fin_r;

  // Wait of the picked job added to the running total.
  assign sum_add = sum_r + WW'(clock_r - CKW'(best_arr_r));

  // One restoring divider step.
  assign trial = {rem_r, quo_r[QW-1]} - {1'b0, loaded_r};

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    dropped_nxt   = dropped_r;
    fin_nxt       = fin_r;
    clock_nxt     = clock_r;
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = rd_vld_r;
    found_nxt     = found_r;
    best_arr_nxt  = best_arr_r;
    best_bur_nxt  = best_bur_r;
    best_idx_nxt  = best_idx_r;
    any_nxt       = any_r;
    earliest_nxt  = earliest_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_wait_nxt  = out_wait_r;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;

    // The result beat leaves when the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!store_full) begin
            fin_nxt[loaded_r[IW-1:0]] = 1'b0;
            loaded_nxt = loaded_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last_job) begin
            clock_nxt  = '0;
            sum_nxt    = '0;
            done_nxt   = '0;
            iss_nxt    = '0;
            rd_vld_nxt = 1'b0;
            found_nxt  = 1'b0;
            any_nxt    = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one store read per cycle.
        rd_vld_nxt = (iss_r != loaded_r);
        if (iss_r != loaded_r) begin
          iss_nxt = iss_r + 1'b1;
        end
        // Compare the entry read in the previous cycle.
        if (rd_vld_r) begin
          if (cand && (!found_r || rd_bur_r < best_bur_r)) begin
            found_nxt    = 1'b1;
            best_arr_nxt = rd_arr_r;
            best_bur_nxt = rd_bur_r;
            best_idx_nxt = rd_idx_r;
          end
          if (pending && (!any_r || rd_arr_r < earliest_r)) begin
            any_nxt      = 1'b1;
            earliest_nxt = rd_arr_r;
          end
        end
        if (iss_r == loaded_r && !rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        iss_nxt    = '0;
        rd_vld_nxt = 1'b0;
        found_nxt  = 1'b0;
        any_nxt    = 1'b0;
        if (found_r) begin
          // Run the picked job.
          sum_nxt             = sum_add;
          clock_nxt           = clock_r + CKW'(best_bur_r);
          fin_nxt[best_idx_r] = 1'b1;
          done_nxt            = done_r + 1'b1;
          if (CW'(done_r + 1'b1) == loaded_r) begin
            rem_nxt   = '0;
            quo_nxt   = {sum_add, {sjfaw_pkg::FRAC_W{1'b0}}};
            step_nxt  = SW'(sjfaw_pkg::DIV_STEPS);
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else if (any_r) begin
          // Nothing has arrived: jump to the earliest pending arrival.
          clock_nxt = CKW'(earliest_r);
          state_nxt = ST_SCAN;
        end else begin
          // Empty batch: the average is zero.
          rem_nxt   = '0;
          quo_nxt   = '0;
          step_nxt  = SW'(sjfaw_pkg::DIV_STEPS);
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (loaded_r == '0) begin
          quo_nxt = '0;
        end else if (!trial[CW]) begin
          rem_nxt = trial[CW-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          // The shifted remainder is below the divisor, so its top bit is zero.
          rem_nxt = CW'({rem_r, quo_r[QW-1]});
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == SW'(1)) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Post the result once the output register is free, then clear.
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_wait_nxt  = sum_r;
          out_avg_nxt   = quo_r;
          out_cnt_nxt   = sjfaw_pkg::COUNT_OUT_W'(loaded_r);
          out_ovf_nxt   = dropped_r;
          loaded_nxt    = '0;
          dropped_nxt   = 1'b0;
          fin_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      dropped_r   <= 1'b0;
      fin_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      dropped_r   <= dropped_nxt;
      fin_r       <= fin_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    clock_r    <= clock_nxt;
    sum_r      <= sum_nxt;
    done_r     <= done_nxt;
    iss_r      <= iss_nxt;
    found_r    <= found_nxt;
    best_arr_r <= best_arr_nxt;
    best_bur_r <= best_bur_nxt;
    best_idx_r <= best_idx_nxt;
    any_r      <= any_nxt;
    earliest_r <= earliest_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    out_wait_r <= out_wait_nxt;
    out_avg_r  <= out_avg_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_total_wait      = out_wait_r;
  assign out_average_wait_q8 = out_avg_r;
  assign out_job_count       = out_cnt_r;
  assign out_overflow        = out_ovf_r;

endmodule
